// ----- rtl/rlds_pkg.sv -----
// Shared constants, codes and types of the ready-list deadline scheduler.
package rlds_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int SLOT_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam int ID_W = 8;
  localparam int DL_W = 16;
  localparam int RSLOT_W = 4;
  localparam int OUT_SLOT_W = 4;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_NEXT   = 2'd2,
    ACT_PICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADSLOT = 2'd2,
    ST_NOSLACK = 2'd3
  } status_t;

  typedef struct packed {
    action_t             op;
    logic [ID_W-1:0]     id;
    logic [DL_W-1:0]     dl;
    logic [RSLOT_W-1:0]  rslot;
    logic [DL_W-1:0]     now;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } entry_t;

endpackage

// ----- rtl/ready_list_deadline_scheduler.sv -----
// Top level of the ready-list deadline scheduler.
//
// Each input transfer (action, new_task_id, new_deadline, remove_slot,
// now_time) yields exactly one output transfer (selected_slot,
// selected_task_id, selected_deadline, entry_count, status), in order.
// Both channels move a transfer at a clock edge where valid is high and
// stall is low.
// An input stage registers and decodes each transfer and hands it through
// a two-entry queue to the list engine, which walks the 16-entry list one
// entry per cycle over a single read port.
// Insert moves the entries from its slot to the list end up by one and
// writes the new entry into the slot, remove moves the entries above
// remove_slot down by one, and deadline pick scans every entry; round-robin
// and any action that ends in an error go straight to readout.
// Reset clears the list count, the current slot and all valid flags; list
// contents are not cleared and need no clearing pass.
// While the output is stalled, the result holds and the engine takes no
// new command; the queue and input stage fill and then stall the input.
module ready_list_deadline_scheduler
  import rlds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [ID_W-1:0]       new_task_id,
  input  logic [DL_W-1:0]       new_deadline,
  input  logic [RSLOT_W-1:0]    remove_slot,
  input  logic [DL_W-1:0]       now_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_SLOT_W-1:0] selected_slot,
  output logic [ID_W-1:0]       selected_task_id,
  output logic [DL_W-1:0]       selected_deadline,
  output logic [OUT_CNT_W-1:0]  entry_count,
  output logic [1:0]            status
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_nonempty;
  cmd_t q_cmd;

  rlds_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .new_task_id  (new_task_id),
    .new_deadline (new_deadline),
    .remove_slot  (remove_slot),
    .now_time     (now_time),
    .cmd_valid    (push),
    .cmd          (push_cmd),
    .cmd_full     (q_full)
  );

  rlds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_cmd)
  );

  rlds_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_avail         (q_nonempty),
    .cmd_in            (q_cmd),
    .cmd_pop           (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .selected_slot     (selected_slot),
    .selected_task_id  (selected_task_id),
    .selected_deadline (selected_deadline),
    .entry_count       (entry_count),
    .status            (status)
  );

endmodule

// ----- rtl/rlds_front.sv -----
// Input stage: registers each transfer and decodes it into a command.
module rlds_front
  import rlds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [ID_W-1:0]    new_task_id,
  input  logic [DL_W-1:0]    new_deadline,
  input  logic [RSLOT_W-1:0] remove_slot,
  input  logic [DL_W-1:0]    now_time,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_full
);

  logic fvalid;
  cmd_t fcmd;
  cmd_t decoded;
  logic push;

  assign push = fvalid && !cmd_full;
  assign in_stall = fvalid && cmd_full;
  assign cmd_valid = push;
  assign cmd = fcmd;

  always_comb begin
    decoded = '0;
    decoded.op = action_t'(action);
    case (action_t'(action))
      ACT_INSERT: begin
        decoded.id = new_task_id;
        decoded.dl = new_deadline;
      end
      ACT_REMOVE: decoded.rslot = remove_slot;
      ACT_PICK: decoded.now = now_time;
      default: decoded.op = ACT_NEXT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (!fvalid || push) begin
      fvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      fcmd <= decoded;
    end
  end

endmodule

// ----- rtl/rlds_queue.sv -----
// Two-entry command queue between the input stage and the list engine.
module rlds_queue
  import rlds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t pop_data
);

  cmd_t slots [2];
  logic wptr;
  logic rptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign nonempty = fill != 2'd0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// ----- rtl/rlds_back.sv -----
// List engine: holds the ready list and walks it one entry per cycle.
module rlds_back
  import rlds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_avail,
  input  cmd_t                  cmd_in,
  output logic                  cmd_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_SLOT_W-1:0] selected_slot,
  output logic [ID_W-1:0]       selected_task_id,
  output logic [DL_W-1:0]       selected_deadline,
  output logic [OUT_CNT_W-1:0]  entry_count,
  output logic [1:0]            status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_SCAN,
    S_READ
  } state_t;

  state_t state;
  entry_t list_mem [LIST_DEPTH];
  cmd_t cmd;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] sel;
  logic [CNT_W-1:0] best;
  logic [DL_W-1:0] best_dl;
  logic found;
  status_t stat;

  logic out_free;
  logic [CNT_W-1:0] pos_next;
  logic [CNT_W-1:0] rr_next;
  logic [SLOT_W-1:0] raddr;
  entry_t rd;
  logic hit;
  logic [CNT_W-1:0] best_fin;
  logic found_fin;
  logic wr_en;
  logic [SLOT_W-1:0] waddr;
  entry_t wdata;

  assign out_free = !out_valid || !out_stall;
  assign cmd_pop = (state == S_IDLE) && cmd_avail && out_free;
  assign pos_next = (cur > count) ? count : cur;
  assign rr_next = (cur + CNT_W'(1) >= count) ? '0 : cur + CNT_W'(1);

  always_comb begin
    case (state)
      S_INS: raddr = SLOT_W'(idx - CNT_W'(1));
      S_REM: raddr = SLOT_W'(idx + CNT_W'(1));
      S_SCAN: raddr = SLOT_W'(idx);
      default: raddr = SLOT_W'(sel);
    endcase
  end

  assign rd = list_mem[raddr];
  assign hit = (rd.dl > cmd.now) && (!found || rd.dl < best_dl);
  assign best_fin = hit ? idx : best;
  assign found_fin = found || hit;

  always_comb begin
    wr_en = 1'b0;
    waddr = SLOT_W'(idx);
    wdata = rd;
    if (state == S_INS) begin
      wr_en = 1'b1;
      if (idx <= pos) begin
        waddr = SLOT_W'(pos);
        wdata.id = cmd.id;
        wdata.dl = cmd.dl;
      end
    end else if (state == S_REM) begin
      wr_en = idx + CNT_W'(1) < count;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cur <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            cmd <= cmd_in;
            sel <= cur;
            stat <= ST_OK;
            found <= 1'b0;
            best <= '0;
            idx <= '0;
            state <= S_READ;
            case (cmd_in.op)
              ACT_INSERT: begin
                if (count >= CNT_W'(LIST_DEPTH)) begin
                  stat <= ST_FULL;
                end else begin
                  pos <= pos_next;
                  idx <= count;
                  state <= S_INS;
                end
              end
              ACT_REMOVE: begin
                if (count == '0 || CNT_W'(cmd_in.rslot) >= count) begin
                  stat <= ST_BADSLOT;
                end else begin
                  idx <= CNT_W'(cmd_in.rslot);
                  state <= S_REM;
                end
              end
              default: begin
                if (count == '0) begin
                  cur <= '0;
                  sel <= '0;
                  stat <= ST_BADSLOT;
                end else if (cmd_in.op == ACT_NEXT) begin
                  cur <= rr_next;
                  sel <= rr_next;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_INS: begin
          if (idx > pos) begin
            idx <= idx - CNT_W'(1);
          end else begin
            count <= count + CNT_W'(1);
            cur <= pos + CNT_W'(1);
            sel <= pos + CNT_W'(1);
            state <= S_READ;
          end
        end
        S_REM: begin
          if (idx + CNT_W'(1) < count) begin
            idx <= idx + CNT_W'(1);
          end else begin
            count <= count - CNT_W'(1);
            state <= S_READ;
          end
        end
        S_SCAN: begin
          if (hit) begin
            best <= idx;
            best_dl <= rd.dl;
            found <= 1'b1;
          end
          if (idx + CNT_W'(1) >= count) begin
            cur <= found_fin ? best_fin : '0;
            sel <= found_fin ? best_fin : '0;
            stat <= found_fin ? ST_OK : ST_NOSLACK;
            state <= S_READ;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          selected_slot <= OUT_SLOT_W'(sel);
          entry_count <= OUT_CNT_W'(count);
          status <= stat;
          if (sel < count) begin
            selected_task_id <= rd.id;
            selected_deadline <= rd.dl;
          end else begin
            selected_task_id <= '0;
            selected_deadline <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("entry count exceeds list depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) || count == $past(count) + CNT_W'(1) ||
         count + CNT_W'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_IDLE && out_valid)
    else $error("result not loaded after readout");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_READ))
    else $error("result loaded outside readout");

endmodule

// ----- bench/tb_ready_list_deadline_scheduler.sv -----
// Self-checking testbench for the ready-list deadline scheduler with a predicting scoreboard.
module tb_ready_list_deadline_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import rlds_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic [ID_W-1:0]       id;
    logic [DL_W-1:0]       dl;
    logic [OUT_CNT_W-1:0]  cnt;
    status_t               st;
  } sched_result_t;

  class sched_tracker;
    logic [ID_W-1:0] ids [LIST_DEPTH];
    logic [DL_W-1:0] dls [LIST_DEPTH];
    int unsigned count;
    int unsigned cur_slot;
    sched_result_t awaited[$];
    int errors;
    int unsigned act_seen[4];
    int unsigned status_seen[4];

    function new();
      count = 0;
      cur_slot = 0;
      errors = 0;
      foreach (act_seen[k]) act_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function sched_result_t outcome(int unsigned slot, status_t st, bit blank);
      sched_result_t r;
      r.slot = OUT_SLOT_W'(slot);
      r.id = '0;
      r.dl = '0;
      if (!blank && slot < count) begin
        r.id = ids[slot];
        r.dl = dls[slot];
      end
      r.cnt = OUT_CNT_W'(count);
      r.st = st;
      return r;
    endfunction

    function void accept_cmd(cmd_t c);
      int i;
      int unsigned pos;
      int unsigned best;
      int slack;
      int best_slack;
      bit found;
      sched_result_t r;
      act_seen[c.op]++;
      case (c.op)
        ACT_INSERT: begin
          if (count >= LIST_DEPTH) begin
            r = outcome(cur_slot, ST_FULL, 1'b0);
          end else begin
            pos = (cur_slot > count) ? count : cur_slot;
            for (i = int'(count); i > int'(pos); i--) begin
              ids[i] = ids[i-1];
              dls[i] = dls[i-1];
            end
            ids[pos] = c.id;
            dls[pos] = c.dl;
            count++;
            cur_slot = pos + 1;
            r = outcome(cur_slot, ST_OK, 1'b0);
          end
        end
        ACT_REMOVE: begin
          if (count == 0 || c.rslot >= count) begin
            r = outcome(cur_slot, ST_BADSLOT, 1'b0);
          end else begin
            for (i = int'(c.rslot); i + 1 < int'(count); i++) begin
              ids[i] = ids[i+1];
              dls[i] = dls[i+1];
            end
            count--;
            r = outcome(cur_slot, ST_OK, 1'b0);
          end
        end
        default: begin
          if (count == 0) begin
            cur_slot = 0;
            r = outcome(0, ST_BADSLOT, 1'b1);
          end else if (c.op == ACT_NEXT) begin
            cur_slot++;
            if (cur_slot >= count) cur_slot = 0;
            r = outcome(cur_slot, ST_OK, 1'b0);
          end else begin
            found = 1'b0;
            best = 0;
            best_slack = 0;
            for (i = 0; i < int'(count); i++) begin
              slack = int'(dls[i]) - int'(c.now);
              if (slack > 0 && (!found || slack < best_slack)) begin
                found = 1'b1;
                best_slack = slack;
                best = i;
              end
            end
            cur_slot = best;
            if (found) r = outcome(best, ST_OK, 1'b0);
            else r = outcome(best, ST_NOSLACK, 1'b0);
          end
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void compare_result(sched_result_t got);
      sched_result_t want;
      if (awaited.size() == 0) begin
        $error("Result transfer with no command awaiting it: slot %0d, status %0d",
               got.slot, got.st);
        errors++;
        return;
      end
      want = awaited.pop_front();
      status_seen[want.st]++;
      if (got.slot !== want.slot) begin
        $error("selected_slot: expected %0d, actual %0d", want.slot, got.slot);
        errors++;
      end
      if (got.id !== want.id) begin
        $error("selected_task_id: expected %0h, actual %0h", want.id, got.id);
        errors++;
      end
      if (got.dl !== want.dl) begin
        $error("selected_deadline: expected %0h, actual %0h", want.dl, got.dl);
        errors++;
      end
      if (got.cnt !== want.cnt) begin
        $error("entry_count: expected %0d, actual %0d", want.cnt, got.cnt);
        errors++;
      end
      if (got.st !== want.st) begin
        $error("status: expected %0d, actual %0d", want.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            action;
  logic [ID_W-1:0]       new_task_id;
  logic [DL_W-1:0]       new_deadline;
  logic [RSLOT_W-1:0]    remove_slot;
  logic [DL_W-1:0]       now_time;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_SLOT_W-1:0] selected_slot;
  logic [ID_W-1:0]       selected_task_id;
  logic [DL_W-1:0]       selected_deadline;
  logic [OUT_CNT_W-1:0]  entry_count;
  logic [1:0]            status;

  sched_tracker board = new();
  cmd_t dir_q[$];
  int unsigned sent_cnt = 0;
  int unsigned idle_cycles = 0;
  logic [DL_W-1:0] base_time = 16'd1000;

  ready_list_deadline_scheduler dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .new_task_id       (new_task_id),
    .new_deadline      (new_deadline),
    .remove_slot       (remove_slot),
    .now_time          (now_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .selected_slot     (selected_slot),
    .selected_task_id  (selected_task_id),
    .selected_deadline (selected_deadline),
    .entry_count       (entry_count),
    .status            (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cmd_t mk(action_t op, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                              logic [RSLOT_W-1:0] rs, logic [DL_W-1:0] now);
    cmd_t c;
    c.op = op;
    c.id = id;
    c.dl = dl;
    c.rslot = rs;
    c.now = now;
    return c;
  endfunction

  // Times cluster around a slowly drifting base so that slack is often small or zero.
  function automatic logic [DL_W-1:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return base_time + DL_W'($urandom_range(0, 32)) - DL_W'(16);
    if (roll < 8) return DL_W'($urandom_range(0, 65535));
    if (roll == 8) return '0;
    return '1;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned roll;
    int unsigned ins_w;
    base_time = base_time + DL_W'($urandom_range(0, 3));
    c.id = ID_W'($urandom_range(0, 255));
    c.dl = pick_time();
    c.now = pick_time();
    if (board.count > 0 && $urandom_range(0, 9) < 8)
      c.rslot = RSLOT_W'($urandom_range(0, board.count - 1));
    else
      c.rslot = RSLOT_W'($urandom_range(0, 15));
    ins_w = (board.count < 4) ? 55 : (board.count >= LIST_DEPTH) ? 15 : 30;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) c.op = ACT_INSERT;
    else if (roll < ins_w + 25) c.op = ACT_REMOVE;
    else if (roll < ins_w + 40) c.op = ACT_NEXT;
    else c.op = ACT_PICK;
    return c;
  endfunction

  task automatic send_item(cmd_t c);
    in_valid <= 1'b1;
    action <= c.op;
    new_task_id <= c.id;
    new_deadline <= c.dl;
    remove_slot <= c.rslot;
    now_time <= c.now;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    board.accept_cmd(c);
    sent_cnt++;
  endtask

  initial begin : stimulus
    cmd_t c;
    int unsigned n;
    int unsigned total;
    int unsigned burst;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_INSERT;
    new_task_id = '0;
    new_deadline = '0;
    remove_slot = '0;
    now_time = '0;
    burst = 0;

    // Empty-list cases, extremes, no positive slack, wrap and bad slots.
    dir_q.push_back(mk(ACT_NEXT, 8'h00, 16'h0000, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_PICK, 8'hff, 16'hffff, 4'hf, 16'hffff));
    dir_q.push_back(mk(ACT_REMOVE, 8'h00, 16'h0000, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_INSERT, 8'h00, 16'h0000, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_INSERT, 8'hff, 16'hffff, 4'hf, 16'hffff));
    dir_q.push_back(mk(ACT_PICK, 8'h00, 16'h0000, 4'h0, 16'hffff));
    dir_q.push_back(mk(ACT_PICK, 8'h00, 16'h0000, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_REMOVE, 8'h00, 16'h0000, 4'hf, 16'h0000));
    dir_q.push_back(mk(ACT_NEXT, 8'h00, 16'h0000, 4'h0, 16'h0000));
    // Fill the list with tied deadlines, then overfill it.
    for (n = 0; n < LIST_DEPTH - 2; n++)
      dir_q.push_back(mk(ACT_INSERT, ID_W'(8'h10 + n), DL_W'(100 + n % 3), 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_INSERT, 8'haa, 16'h5555, 4'h0, 16'h0000));
    // Shrink below the current slot so the next insert appends.
    dir_q.push_back(mk(ACT_REMOVE, 8'h00, 16'h0000, 4'hf, 16'h0000));
    dir_q.push_back(mk(ACT_REMOVE, 8'h00, 16'h0000, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_REMOVE, 8'h00, 16'h0000, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_INSERT, 8'h5a, 16'd100, 4'h0, 16'h0000));
    dir_q.push_back(mk(ACT_PICK, 8'h00, 16'h0000, 4'h0, 16'd99));

    total = dir_q.size() + RANDOM_ITEMS;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < total; n++) begin
      if (n != 0) begin
        if (burst != 0) begin
          burst--;
        end else begin
          burst = $urandom_range(0, 30);
          if ($urandom_range(0, 3) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
      end
      c = (n < dir_q.size()) ? dir_q[n] : random_cmd();
      send_item(c);
    end
    in_valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transfers: %0d inserts, %0d removes, %0d round-robin, %0d picks.",
             sent_cnt, board.act_seen[ACT_INSERT], board.act_seen[ACT_REMOVE],
             board.act_seen[ACT_NEXT], board.act_seen[ACT_PICK]);
    $display("Results by status: %0d ok, %0d full, %0d empty/bad slot, %0d no slack.",
             board.status_seen[ST_OK], board.status_seen[ST_FULL],
             board.status_seen[ST_BADSLOT], board.status_seen[ST_NOSLACK]);
    if (board.errors == 0) begin
      $display("[ready_list_deadline_scheduler] OK");
    end else begin
      $display("[ready_list_deadline_scheduler] ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned len;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    forever begin
      if (!held && sent_cnt >= HOLD_AT) begin
        held = 1'b1;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(10, 60);
      repeat (len) begin
        @(posedge clk);
        if (mode == 0) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < ((mode == 1) ? 30 : 75));
      end
    end
  end

  always @(negedge clk) begin
    sched_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.slot = selected_slot;
      got.id = selected_task_id;
      got.dl = selected_deadline;
      got.cnt = entry_count;
      got.st = status_t'(status);
      board.compare_result(got);
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[ready_list_deadline_scheduler] ERROR");
      $finish;
    end
  end

endmodule
